// File: rtl/core/dcdk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcdk_pkg
// shared types and constants for the kahn cycle detector
// ----------------------------------------------------------------------------
package dcdk_pkg;

    localparam int unsigned MaxVertices = 256;
    localparam int unsigned MaxEdges    = 1024;
    localparam int unsigned VtxW        = 8;
    localparam int unsigned EdgeW       = 10;
    localparam int unsigned LinkW       = 11;
    localparam int unsigned CntW        = 9;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] source_vertex;
        logic [7:0] target_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic       has_cycle;
        logic [8:0] visited_count;
    } t_out_beat;

    // edge store write request
    typedef struct packed {
        logic             we;
        logic [EdgeW-1:0] addr;
        logic [VtxW-1:0]  target;
        logic [LinkW-1:0] next;
    } t_edge_wr;

endpackage
`default_nettype wire

// File: rtl/core/dcdk_edge_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcdk_edge_mem
// edge store: target and next link per edge, one write and one read port
// ----------------------------------------------------------------------------
module dcdk_edge_mem (
    input  wire logic                          i_clk,
    input  wire dcdk_pkg::t_edge_wr            i_wr,
    input  wire logic [dcdk_pkg::EdgeW-1:0]    i_raddr,
    output logic      [dcdk_pkg::VtxW-1:0]     o_target,
    output logic      [dcdk_pkg::LinkW-1:0]    o_next
);

    logic [dcdk_pkg::VtxW-1:0]  r_tgt  [dcdk_pkg::MaxEdges];
    logic [dcdk_pkg::LinkW-1:0] r_link [dcdk_pkg::MaxEdges];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_tgt[i_wr.addr]  <= i_wr.target;
            r_link[i_wr.addr] <= i_wr.next;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_target <= r_tgt[i_raddr];
        o_next   <= r_link[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/directed_cycle_detect_kahn_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// directed_cycle_detect_kahn_core
// directed graph store with a kahn topological pass for cycle detection
// ----------------------------------------------------------------------------
// usage
//   a command beat on i_in_beat is taken at a rising edge with start high
//   and busy low. exactly one result beat follows on o_out_beat, marked by
//   o_done for one cycle; the receiver cannot stall it.
//   add edge: the sequencer passes through S_ADD to S_DONE; reserved goes
//   straight to S_DONE. a new command is taken once it is back in idle.
//   clear: a sweep over the 256 chain heads, then S_DONE reports.
//   evaluate: with the single read port of each memory the pass runs in
//   steps: one pass clears in-degrees, one walks all chains counting, one
//   scans for zero in-degree, then each popped vertex walks its chain.
//   i_cfg_we with i_cfg_data writes vertex_count, sampled when a command
//   is taken.
//   after reset a sweep nulls the 256 chain heads; busy stays high.
// ----------------------------------------------------------------------------
module directed_cycle_detect_kahn_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire dcdk_pkg::t_in_beat   i_in_beat,
    output logic                      o_done,
    output dcdk_pkg::t_out_beat       o_out_beat,
    input  wire logic                 i_cfg_we,
    input  wire logic [8:0]           i_cfg_data
);

    localparam int unsigned VW = dcdk_pkg::VtxW;
    localparam int unsigned LW = dcdk_pkg::LinkW;

    typedef enum logic [14:0] {
        S_INIT   = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_ADD    = 15'b000000000000100,
        S_ZERO   = 15'b000000000001000,
        S_CRD    = 15'b000000000010000,
        S_CHEAD  = 15'b000000000100000,
        S_CEDGE  = 15'b000000001000000,
        S_CINC   = 15'b000000010000000,
        S_SCAN   = 15'b000000100000000,
        S_POP    = 15'b000001000000000,
        S_PHEAD  = 15'b000010000000000,
        S_PEDGE  = 15'b000100000000000,
        S_PDEC   = 15'b001000000000000,
        S_QRD    = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state r_state;
    logic [8:0]  r_vcnt;
    logic [8:0]  r_n;
    logic [LW-1:0] r_etot;
    logic [8:0]  r_idx;       // vertex sweep counter
    logic [VW-1:0] r_src, r_dst;
    logic [LW-1:0] r_edge;
    logic [8:0]  r_qh, r_qt, r_removed;
    logic [1:0]  r_status;
    logic        r_cyc;
    logic        r_clr;       // head sweep serves a clear command
    logic        r_scan_rd;   // scan: read in flight
    logic [VW-1:0] r_scan_v;

    // chain head memory
    logic [LW-1:0] r_head [dcdk_pkg::MaxVertices];
    logic [LW-1:0] r_head_q;
    logic          head_we;
    logic [VW-1:0] head_wa, head_ra;
    logic [LW-1:0] head_wd;
    always_ff @(posedge i_clk) begin
        if (head_we) r_head[head_wa] <= head_wd;
        r_head_q <= r_head[head_ra];
    end

    // in-degree memory
    logic [LW-1:0] r_deg [dcdk_pkg::MaxVertices];
    logic [LW-1:0] r_deg_q;
    logic          deg_we;
    logic [VW-1:0] deg_wa, deg_ra;
    logic [LW-1:0] deg_wd;
    always_ff @(posedge i_clk) begin
        if (deg_we) r_deg[deg_wa] <= deg_wd;
        r_deg_q <= r_deg[deg_ra];
    end

    // ready queue memory
    logic [VW-1:0] r_q [dcdk_pkg::MaxVertices];
    logic [VW-1:0] r_q_q;
    logic          q_we;
    logic [VW-1:0] q_wd;
    always_ff @(posedge i_clk) begin
        if (q_we) r_q[r_qt[VW-1:0]] <= q_wd;
        r_q_q <= r_q[r_qh[VW-1:0]];
    end

    // edge store
    dcdk_pkg::t_edge_wr edge_wr;
    logic [dcdk_pkg::EdgeW-1:0] edge_ra;
    logic [VW-1:0] edge_tgt;
    logic [LW-1:0] edge_nxt;
    dcdk_edge_mem u_edge (
        .i_clk    (i_clk),
        .i_wr     (edge_wr),
        .i_raddr  (edge_ra),
        .o_target (edge_tgt),
        .o_next   (edge_nxt)
    );

    logic [8:0] eff_n;
    logic       last_v;
    logic       tgt_ok;
    assign eff_n  = (r_vcnt > 9'd256) ? 9'd256 : r_vcnt;
    assign last_v = (r_idx + 9'd1 >= r_n);
    assign tgt_ok = ({1'b0, edge_tgt} < r_n);

    // memory port steering
    always_comb begin
        head_we = 1'b0;
        head_wa = r_idx[VW-1:0];
        head_wd = LW'(dcdk_pkg::MaxEdges);
        head_ra = r_idx[VW-1:0];
        deg_we  = 1'b0;
        deg_wa  = r_idx[VW-1:0];
        deg_wd  = '0;
        deg_ra  = r_idx[VW-1:0];
        q_we    = 1'b0;
        q_wd    = r_idx[VW-1:0];
        edge_wr = '0;
        edge_ra = r_edge[dcdk_pkg::EdgeW-1:0];
        unique case (r_state)
            S_INIT: head_we = 1'b1;
            S_IDLE: begin
                head_ra = i_in_beat.source_vertex;
                if (start && i_in_beat.opcode == dcdk_pkg::OP_CLEAR) begin
                    head_we = 1'b0;
                end
            end
            S_ADD: begin
                // head of source was read last cycle
                if (r_status == dcdk_pkg::ST_OK) begin
                    edge_wr.we     = 1'b1;
                    edge_wr.addr   = r_etot[dcdk_pkg::EdgeW-1:0];
                    edge_wr.target = r_dst;
                    edge_wr.next   = r_head_q;
                    head_we        = 1'b1;
                    head_wa        = r_src;
                    head_wd        = r_etot;
                end
            end
            S_ZERO: deg_we = 1'b1;
            S_CHEAD: edge_ra = r_head_q[dcdk_pkg::EdgeW-1:0];
            S_CEDGE: begin
                deg_ra  = edge_tgt;
                edge_ra = edge_nxt[dcdk_pkg::EdgeW-1:0];
            end
            S_CINC: begin
                deg_we = 1'b1;
                deg_wa = r_dst;
                deg_wd = r_deg_q + LW'(1);
            end
            S_SCAN: begin
                deg_ra = r_idx[VW-1:0];
                if (r_scan_rd && r_deg_q == '0) begin
                    q_we = 1'b1;
                    q_wd = r_scan_v;
                end
            end
            S_POP: head_ra = r_q_q;
            S_PHEAD: edge_ra = r_head_q[dcdk_pkg::EdgeW-1:0];
            S_PEDGE: begin
                deg_ra  = edge_tgt;
                edge_ra = edge_nxt[dcdk_pkg::EdgeW-1:0];
            end
            S_PDEC: begin
                deg_we = 1'b1;
                deg_wa = r_dst;
                deg_wd = r_deg_q - LW'(1);
                if (r_deg_q == LW'(1) && r_qt < r_n) begin
                    q_we = 1'b1;
                    q_wd = r_dst;
                end
            end
            default: ;
        endcase
        if (r_state == S_IDLE && start && i_in_beat.opcode == dcdk_pkg::OP_CLEAR) begin
            head_we = 1'b0;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_vcnt    <= 9'd1;
            r_etot    <= '0;
            r_idx     <= '0;
            o_done    <= 1'b0;
            r_scan_rd <= 1'b0;
            r_clr     <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) r_vcnt <= i_cfg_data;
            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'd255) begin
                        r_state <= r_clr ? S_DONE : S_IDLE;
                        r_etot  <= '0;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_src     <= i_in_beat.source_vertex;
                        r_dst     <= i_in_beat.target_vertex;
                        r_n       <= eff_n;
                        r_status  <= dcdk_pkg::ST_OK;
                        r_cyc     <= 1'b0;
                        r_clr     <= 1'b0;
                        r_removed <= '0;
                        r_idx     <= '0;
                        r_qh      <= '0;
                        r_qt      <= '0;
                        case (i_in_beat.opcode)
                            dcdk_pkg::OP_ADD: begin
                                if ({1'b0, i_in_beat.source_vertex} >= eff_n ||
                                    {1'b0, i_in_beat.target_vertex} >= eff_n)
                                    r_status <= dcdk_pkg::ST_RANGE;
                                else if (r_etot >= LW'(dcdk_pkg::MaxEdges))
                                    r_status <= dcdk_pkg::ST_FULL;
                                r_state <= S_ADD;
                            end
                            dcdk_pkg::OP_EVAL: begin
                                r_state <= (eff_n == 9'd0) ? S_DONE : S_ZERO;
                            end
                            dcdk_pkg::OP_CLEAR: begin
                                // reuse the head sweep, then report
                                r_clr   <= 1'b1;
                                r_state <= S_INIT;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_ADD: begin
                    if (r_status == dcdk_pkg::ST_OK) r_etot <= r_etot + LW'(1);
                    r_state <= S_DONE;
                end
                S_ZERO: begin
                    r_idx <= r_idx + 9'd1;
                    if (last_v) begin
                        r_idx   <= '0;
                        r_state <= S_CRD;
                    end
                end
                S_CRD: r_state <= S_CHEAD;
                S_CHEAD: begin
                    // head of r_idx now on r_head_q
                    if (r_head_q[LW-1]) begin
                        r_idx <= r_idx + 9'd1;
                        if (last_v) begin
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end else begin
                        r_edge  <= r_head_q;
                        r_state <= S_CEDGE;
                    end
                end
                S_CEDGE: begin
                    r_dst  <= edge_tgt;
                    r_edge <= edge_nxt;
                    r_state <= tgt_ok ? S_CINC : S_CRD;
                    if (!tgt_ok) begin
                        if (edge_nxt[LW-1]) begin
                            r_idx <= r_idx + 9'd1;
                            if (last_v) begin
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                        end else r_state <= S_CEDGE;
                    end
                end
                S_CINC: begin
                    if (r_edge[LW-1]) begin
                        r_idx <= r_idx + 9'd1;
                        if (last_v) begin
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end else r_state <= S_CRD;
                    end else r_state <= S_CEDGE;
                end
                S_SCAN: begin
                    r_scan_rd <= (r_idx < r_n);
                    r_scan_v  <= r_idx[VW-1:0];
                    if (r_scan_rd && r_deg_q == '0) r_qt <= r_qt + 9'd1;
                    if (r_idx < r_n) r_idx <= r_idx + 9'd1;
                    else begin
                        r_scan_rd <= 1'b0;
                        if (!r_scan_rd) r_state <= S_POP;
                    end
                end
                S_POP: begin
                    // r_q_q holds entry r_qh once the queue address settled
                    if (r_qh >= r_qt) begin
                        r_state <= S_DONE;
                        r_cyc   <= (r_removed < r_n);
                    end else begin
                        r_qh      <= r_qh + 9'd1;
                        r_removed <= r_removed + 9'd1;
                        r_state   <= S_PHEAD;
                    end
                end
                S_PHEAD: begin
                    if (r_head_q[LW-1]) r_state <= S_POP;
                    else begin
                        r_edge  <= r_head_q;
                        r_state <= S_PEDGE;
                    end
                end
                S_PEDGE: begin
                    r_dst  <= edge_tgt;
                    r_edge <= edge_nxt;
                    if (tgt_ok) r_state <= S_PDEC;
                    else if (edge_nxt[LW-1]) r_state <= S_POP;
                end
                S_PDEC: begin
                    if (r_deg_q == LW'(1) && r_qt < r_n) r_qt <= r_qt + 9'd1;
                    r_state <= r_edge[LW-1] ? S_QRD : S_PEDGE;
                end
                // let a queue write from the last decrement land before the read
                S_QRD: r_state <= S_POP;
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_out_beat.status        <= r_status;
            o_out_beat.has_cycle     <= r_cyc;
            o_out_beat.visited_count <= r_removed;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the kahn cycle detector: a queue-fed driver sends
// add edge, evaluate, clear and reserved commands in random bursts, a graph
// predictor computes each expected result beat, and a monitor compares every
// o_done beat field by field. vertex_count is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WatchdogLimit = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    dcdk_pkg::t_in_beat  in_beat;
    logic      o_done;
    dcdk_pkg::t_out_beat out_beat;
    logic      i_cfg_we;
    logic [8:0] i_cfg_data;

    directed_cycle_detect_kahn_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_beat  (in_beat),
        .o_done     (o_done),
        .o_out_beat (out_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // graph mirror
    int unsigned vtx_count_reg;
    int unsigned edge_tgt [dcdk_pkg::MaxEdges];
    int unsigned edge_nxt [dcdk_pkg::MaxEdges];
    int unsigned chain_head [dcdk_pkg::MaxVertices];
    int unsigned edge_cnt;

    dcdk_pkg::t_in_beat  pending_cmds [$];
    dcdk_pkg::t_out_beat expected_beats [$];
    int        error_cnt;
    int        cmd_total;
    logic      took;
    int        gap_left;
    int        burst_left;
    int        idle_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_cnt++;
    endtask

    function automatic int unsigned eff_count();
        return (vtx_count_reg > dcdk_pkg::MaxVertices) ? dcdk_pkg::MaxVertices
                                                       : vtx_count_reg;
    endfunction

    // kahn pass over the mirrored edge chains
    function automatic int unsigned kahn_removed();
        int unsigned n;
        int unsigned indeg [dcdk_pkg::MaxVertices];
        int unsigned ready [dcdk_pkg::MaxVertices];
        int unsigned qh;
        int unsigned qt;
        int unsigned removed;
        int unsigned u;
        int unsigned e;
        int unsigned t;
        n = eff_count();
        qh = 0;
        qt = 0;
        removed = 0;
        for (u = 0; u < n; u++) indeg[u] = 0;
        for (u = 0; u < n; u++)
            for (e = chain_head[u]; e < dcdk_pkg::MaxEdges; e = edge_nxt[e])
                if (edge_tgt[e] < n) indeg[edge_tgt[e]]++;
        for (u = 0; u < n; u++)
            if (indeg[u] == 0) ready[qt++] = u;
        while (qh < qt) begin
            u = ready[qh++];
            removed++;
            for (e = chain_head[u]; e < dcdk_pkg::MaxEdges; e = edge_nxt[e]) begin
                t = edge_tgt[e];
                if (t < n) begin
                    indeg[t]--;
                    if (indeg[t] == 0 && qt < n) ready[qt++] = t;
                end
            end
        end
        return removed;
    endfunction

    function automatic dcdk_pkg::t_out_beat predict_graph_cmd(input dcdk_pkg::t_in_beat cmd);
        dcdk_pkg::t_out_beat r;
        int unsigned n;
        int unsigned removed;
        r = '0;
        n = eff_count();
        case (cmd.opcode)
            dcdk_pkg::OP_ADD: begin
                if (cmd.source_vertex >= n || cmd.target_vertex >= n) begin
                    r.status = dcdk_pkg::ST_RANGE;
                end else if (edge_cnt >= dcdk_pkg::MaxEdges) begin
                    r.status = dcdk_pkg::ST_FULL;
                end else begin
                    edge_tgt[edge_cnt] = cmd.target_vertex;
                    edge_nxt[edge_cnt] = chain_head[cmd.source_vertex];
                    chain_head[cmd.source_vertex] = edge_cnt;
                    edge_cnt++;
                end
            end
            dcdk_pkg::OP_EVAL: begin
                removed = kahn_removed();
                r.has_cycle = (removed < n);
                r.visited_count = removed[8:0];
            end
            dcdk_pkg::OP_CLEAR: begin
                foreach (chain_head[i]) chain_head[i] = dcdk_pkg::MaxEdges;
                edge_cnt = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // acceptance and prediction
    always @(posedge i_clk) begin
        took <= start && !busy;
        if (i_rst_n && start && !busy)
            expected_beats.insert(expected_beats.size(), predict_graph_cmd(in_beat));
    end

    // result monitor
    always @(posedge i_clk) begin
        dcdk_pkg::t_out_beat exp_beat;
        if (i_rst_n && o_done) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                exp_beat = expected_beats.pop_front();
                if (out_beat.status !== exp_beat.status)
                    report_mismatch($sformatf("status %0d exp %0d",
                        out_beat.status, exp_beat.status));
                if (out_beat.has_cycle !== exp_beat.has_cycle)
                    report_mismatch($sformatf("has_cycle %0d exp %0d",
                        out_beat.has_cycle, exp_beat.has_cycle));
                if (out_beat.visited_count !== exp_beat.visited_count)
                    report_mismatch($sformatf("visited_count %0d exp %0d",
                        out_beat.visited_count, exp_beat.visited_count));
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // command driver, bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
            in_beat <= pending_cmds.pop_front();
            start <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 20);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    task automatic push_cmd(input dcdk_pkg::t_opcode op, input int unsigned src,
                            input int unsigned dst);
        dcdk_pkg::t_in_beat c;
        c.opcode = op;
        c.source_vertex = src[7:0];
        c.target_vertex = dst[7:0];
        pending_cmds.insert(pending_cmds.size(), c);
        cmd_total++;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start || expected_beats.size() > 0 || busy)
            @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input int unsigned v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[8:0];
        vtx_count_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // one graph phase: clear, edges, evaluate, maybe a lowered count
    task automatic random_phase();
        int unsigned n;
        int unsigned ne;
        int unsigned s;
        int unsigned d;
        bit acyclic;
        case ($urandom_range(0, 9))
            0:       n = 256;
            1:       n = $urandom_range(257, 511);
            2:       n = $urandom_range(0, 1);
            default: n = $urandom_range(2, 24);
        endcase
        write_vertex_count(n);
        acyclic = $urandom_range(0, 1);
        push_cmd(dcdk_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
        ne = $urandom_range(1, 30);
        for (int i = 0; i < ne; i++) begin
            s = $urandom_range(0, 255);
            d = $urandom_range(0, 255);
            if ($urandom_range(0, 9) != 0 && eff_count() > 0) begin
                s = $urandom_range(0, eff_count() - 1);
                d = $urandom_range(0, eff_count() - 1);
                if (acyclic && s > d) begin
                    s = s ^ d; d = s ^ d; s = s ^ d;
                end
                if (acyclic && s == d) d = (d + 1 < eff_count()) ? d + 1 : d;
            end
            push_cmd(dcdk_pkg::OP_ADD, s, d);
            if ($urandom_range(0, 15) == 0) push_cmd(dcdk_pkg::OP_RSVD, $urandom, $urandom);
            if ($urandom_range(0, 7) == 0) push_cmd(dcdk_pkg::OP_EVAL, $urandom, $urandom);
        end
        push_cmd(dcdk_pkg::OP_EVAL, $urandom, $urandom);
        if ($urandom_range(0, 2) == 0 && eff_count() > 1) begin
            write_vertex_count($urandom_range(1, eff_count() - 1));
            push_cmd(dcdk_pkg::OP_EVAL, $urandom, $urandom);
        end
    endtask

    initial begin
        error_cnt = 0;
        cmd_total = 0;
        gap_left = 0;
        burst_left = 1;
        start = 1'b0;
        in_beat = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        vtx_count_reg = 1;
        edge_cnt = 0;
        foreach (chain_head[i]) chain_head[i] = dcdk_pkg::MaxEdges;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of one: self loop and range rejects
        push_cmd(dcdk_pkg::OP_EVAL, 0, 0);
        push_cmd(dcdk_pkg::OP_ADD, 0, 0);
        push_cmd(dcdk_pkg::OP_ADD, 1, 0);
        push_cmd(dcdk_pkg::OP_EVAL, 255, 255);
        push_cmd(dcdk_pkg::OP_RSVD, 255, 255);
        // zero vertices rejects every edge
        write_vertex_count(0);
        push_cmd(dcdk_pkg::OP_ADD, 0, 0);
        push_cmd(dcdk_pkg::OP_EVAL, 0, 0);
        // full size: extreme vertex numbers and a two-node cycle
        write_vertex_count(256);
        push_cmd(dcdk_pkg::OP_CLEAR, 255, 255);
        push_cmd(dcdk_pkg::OP_ADD, 255, 0);
        push_cmd(dcdk_pkg::OP_ADD, 0, 255);
        push_cmd(dcdk_pkg::OP_EVAL, 0, 0);
        push_cmd(dcdk_pkg::OP_CLEAR, 0, 0);
        push_cmd(dcdk_pkg::OP_ADD, 0, 255);
        push_cmd(dcdk_pkg::OP_EVAL, 0, 0);
        // count above the vertex limit, then lowered below loaded edges
        write_vertex_count(511);
        push_cmd(dcdk_pkg::OP_ADD, 255, 254);
        push_cmd(dcdk_pkg::OP_ADD, 254, 255);
        push_cmd(dcdk_pkg::OP_EVAL, 0, 0);
        write_vertex_count(255);
        push_cmd(dcdk_pkg::OP_EVAL, 0, 0);
        push_cmd(dcdk_pkg::OP_ADD, 255, 1);

        while (cmd_total < 750) random_phase();

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
